[hw/rtl/spimt_pkg.sv]
// ----------------------------------------------------------------------------
// spimt_pkg
// Shared types and constants of the spi master transfer unit.
// ----------------------------------------------------------------------------
package spimt_pkg;

    localparam int MAX_BITS  = 32;
    localparam int WORD_BITS = 32;
    localparam int COUNT_W   = 6;
    localparam int BIT_IDX_W = $clog2(WORD_BITS);
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 1;

    localparam int COUNT_LIMIT = (MAX_BITS < WORD_BITS) ? MAX_BITS : WORD_BITS;

    localparam int IN_DATA_W  = 40;
    localparam int OUT_DATA_W = 40;

    // item kinds
    localparam logic OP_START = 1'b0;
    localparam logic OP_TICK  = 1'b1;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_CLOCK_POLARITY  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CLOCK_PHASE     = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ENABLE_POLARITY = 2'd2;

    typedef struct packed {
        logic                 opcode;
        logic [COUNT_W-1:0]   bit_count;
        logic [WORD_BITS-1:0] write_word;
        logic                 miso_level;
    } item_t;

    typedef struct packed {
        logic                 sclk_level;
        logic                 mosi_level;
        logic                 enable_level;
        logic                 busy_res;
        logic                 done_res;
        logic [WORD_BITS-1:0] read_word;
    } result_t;

endpackage

[hw/rtl/spimt_in_stage.sv]
// ----------------------------------------------------------------------------
// spimt_in_stage
// Input register: holds one incoming beat until the core takes it.
// ----------------------------------------------------------------------------
module spimt_in_stage
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [spimt_pkg::IN_DATA_W-1:0]    s_tdata,   // bit_count, write_word, miso_level
    input  logic                               s_tuser,   // opcode
    input  logic                               advance,
    output logic                               item_valid,
    output spimt_pkg::item_t                   item
);

    logic              valid_reg;
    logic              valid_next;
    spimt_pkg::item_t  item_reg;
    logic              load;

    assign s_tready = !valid_reg || advance;
    assign load     = s_tvalid && s_tready;

    always_comb
    begin
        valid_next = valid_reg;
        if (load)
        begin
            valid_next = 1'b1;
        end
        else if (advance)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            item_reg.opcode     <= s_tuser;
            item_reg.bit_count  <= s_tdata[spimt_pkg::COUNT_W-1:0];
            item_reg.write_word <= s_tdata[spimt_pkg::COUNT_W +: spimt_pkg::WORD_BITS];
            item_reg.miso_level <= s_tdata[spimt_pkg::COUNT_W + spimt_pkg::WORD_BITS];
        end
    end

    assign item_valid = valid_reg;
    assign item       = item_reg;

endmodule

[hw/rtl/spimt_core.sv]
// ----------------------------------------------------------------------------
// spimt_core
// Transfer state, mode registers and the per-beat step of the spi master.
// ----------------------------------------------------------------------------
module spimt_core
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [spimt_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [spimt_pkg::CFG_DATA_W-1:0]    cfg_data,
    input  logic                                advance,
    input  spimt_pkg::item_t                    item,
    output spimt_pkg::result_t                  result
);

    logic                            cpol_reg, cpha_reg, epol_reg;
    logic [spimt_pkg::WORD_BITS-1:0] shift_out_reg, shift_out_next;
    logic [spimt_pkg::WORD_BITS-1:0] shift_in_reg, shift_in_next;
    logic [spimt_pkg::COUNT_W-1:0]   bits_left_reg, bits_left_next;
    logic                            half_phase_reg, half_phase_next;
    logic                            clock_line_reg, clock_line_next;
    logic                            data_line_reg, data_line_next;
    logic                            active_reg, active_next;

    logic [spimt_pkg::COUNT_W-1:0]   count;
    logic [spimt_pkg::COUNT_W-1:0]   count_m1;
    logic [spimt_pkg::COUNT_W-1:0]   left_m1;
    logic [spimt_pkg::COUNT_W-1:0]   left_m2;
    logic [spimt_pkg::WORD_BITS-1:0] shifted_in;
    logic                            done;
    logic [spimt_pkg::WORD_BITS-1:0] rd;

    always_comb
    begin
        count = item.bit_count;
        if (item.bit_count > spimt_pkg::COUNT_W'(spimt_pkg::COUNT_LIMIT))
        begin
            count = spimt_pkg::COUNT_W'(spimt_pkg::COUNT_LIMIT);
        end
    end

    assign count_m1   = count - 1'b1;
    assign left_m1    = bits_left_reg - 1'b1;
    assign left_m2    = bits_left_reg - 2'd2;
    assign shifted_in = {shift_in_reg[spimt_pkg::WORD_BITS-2:0], item.miso_level};

    always_comb
    begin
        shift_out_next  = shift_out_reg;
        shift_in_next   = shift_in_reg;
        bits_left_next  = bits_left_reg;
        half_phase_next = half_phase_reg;
        clock_line_next = clock_line_reg;
        data_line_next  = data_line_reg;
        active_next     = active_reg;
        done            = 1'b0;
        rd              = '0;
        if (item.opcode == spimt_pkg::OP_START)
        begin
            if (!active_reg)
            begin
                clock_line_next = cpol_reg;
                half_phase_next = 1'b0;
                shift_in_next   = '0;
                if (count == '0)
                begin
                    done           = 1'b1;
                    bits_left_next = '0;
                end
                else
                begin
                    shift_out_next = item.write_word;
                    bits_left_next = count;
                    active_next    = 1'b1;
                    if (!cpha_reg)
                    begin
                        data_line_next = item.write_word[count_m1[spimt_pkg::BIT_IDX_W-1:0]];
                    end
                end
            end
        end
        else if (active_reg)
        begin
            clock_line_next = !clock_line_reg;
            if (!half_phase_reg)
            begin
                // leading edge
                if (!cpha_reg)
                begin
                    shift_in_next = shifted_in;
                end
                else
                begin
                    data_line_next = shift_out_reg[left_m1[spimt_pkg::BIT_IDX_W-1:0]];
                end
                half_phase_next = 1'b1;
            end
            else
            begin
                // trailing edge closes one bit
                if (cpha_reg)
                begin
                    shift_in_next = shifted_in;
                end
                half_phase_next = 1'b0;
                bits_left_next  = left_m1;
                if (left_m1 == '0)
                begin
                    active_next = 1'b0;
                    done        = 1'b1;
                    rd          = shift_in_next;
                end
                else if (!cpha_reg)
                begin
                    data_line_next = shift_out_reg[left_m2[spimt_pkg::BIT_IDX_W-1:0]];
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cpol_reg       <= 1'b0;
            cpha_reg       <= 1'b0;
            epol_reg       <= 1'b0;
            shift_out_reg  <= '0;
            shift_in_reg   <= '0;
            bits_left_reg  <= '0;
            half_phase_reg <= 1'b0;
            clock_line_reg <= 1'b0;
            data_line_reg  <= 1'b0;
            active_reg     <= 1'b0;
        end
        else if (advance)
        begin
            shift_out_reg  <= shift_out_next;
            shift_in_reg   <= shift_in_next;
            bits_left_reg  <= bits_left_next;
            half_phase_reg <= half_phase_next;
            clock_line_reg <= clock_line_next;
            data_line_reg  <= data_line_next;
            active_reg     <= active_next;
        end
        else if (cfg_we && !active_reg)
        begin
            unique case (cfg_index)
                spimt_pkg::CFG_CLOCK_POLARITY:
                begin
                    cpol_reg       <= cfg_data[0];
                    clock_line_reg <= cfg_data[0];
                end
                spimt_pkg::CFG_CLOCK_PHASE:
                begin
                    cpha_reg <= cfg_data[0];
                end
                spimt_pkg::CFG_ENABLE_POLARITY:
                begin
                    epol_reg <= cfg_data[0];
                end
                default:
                begin
                end
            endcase
        end
    end

    always_comb
    begin
        result.sclk_level   = clock_line_next;
        result.mosi_level   = data_line_next;
        result.enable_level = active_next ? epol_reg : !epol_reg;
        result.busy_res     = active_next;
        result.done_res     = done;
        result.read_word    = rd;
    end

endmodule

[hw/rtl/spimt_out_stage.sv]
// ----------------------------------------------------------------------------
// spimt_out_stage
// Result register: holds one result beat until the sink takes it.
// ----------------------------------------------------------------------------
module spimt_out_stage
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               item_valid,
    input  spimt_pkg::result_t                 result,
    output logic                               advance,
    output logic                               m_tvalid,
    input  logic                               m_tready,
    // sclk_level, mosi_level, enable_level, busy_res, done_res, read_word, zero pad
    output logic [spimt_pkg::OUT_DATA_W-1:0]   m_tdata
);

    localparam int PAD_W = spimt_pkg::OUT_DATA_W - 5 - spimt_pkg::WORD_BITS;

    logic                valid_reg;
    logic                valid_next;
    spimt_pkg::result_t  result_reg;

    assign advance = item_valid && (!valid_reg || m_tready);

    always_comb
    begin
        valid_next = valid_reg;
        if (advance)
        begin
            valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            result_reg <= result;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = {{PAD_W{1'b0}},
                       result_reg.read_word,
                       result_reg.done_res,
                       result_reg.busy_res,
                       result_reg.enable_level,
                       result_reg.mosi_level,
                       result_reg.sclk_level};

endmodule

[hw/rtl/spi_master_transfer_unit.sv]
// ----------------------------------------------------------------------------
// spi_master_transfer_unit
// SPI master, 1 to 32 bits MSB first, stepped by start and half-period beats.
// ----------------------------------------------------------------------------
// A start beat (opcode 0) received while idle loads the word and bit count and
// asserts the enable line, or returns done at once for a zero count; each tick
// beat (opcode 1) is one half period of the serial clock. Every beat returns one
// result beat with the line levels, busy and done flags and, on done, the
// captured read word. One beat is taken every clock cycle while the sink takes
// results; the result register captures each result as the core updates its
// state. Mode registers (clock polarity, phase, enable polarity) are written
// through the cfg port while no transfer is in progress.
module spi_master_transfer_unit
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_we,
    input  logic [spimt_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [spimt_pkg::CFG_DATA_W-1:0]   cfg_data,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    // bit_count, write_word, miso_level, zero pad
    input  logic [spimt_pkg::IN_DATA_W-1:0]    s_tdata,
    // opcode
    input  logic                               s_tuser,
    output logic                               m_tvalid,
    input  logic                               m_tready,
    // sclk_level, mosi_level, enable_level, busy_res, done_res, read_word, zero pad
    output logic [spimt_pkg::OUT_DATA_W-1:0]   m_tdata
);

    logic                item_valid;
    logic                advance;
    spimt_pkg::item_t    item;
    spimt_pkg::result_t  result;

    spimt_in_stage u_in_stage
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .advance    (advance),
        .item_valid (item_valid),
        .item       (item)
    );

    spimt_core u_core
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .advance   (advance),
        .item      (item),
        .result    (result)
    );

    spimt_out_stage u_out_stage
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .result     (result),
        .advance    (advance),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata)
    );

endmodule
